// ----- rtl/fosq_pkg.sv -----
// Package for the process queue: command, status and mode codes,
// word types of both channels and the types passed along the cell chain.
// No dependencies.
package fosq_pkg;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [1:0] MODE_FIFO      = 2'd0;
	localparam logic [1:0] MODE_REMAINING = 2'd1;
	localparam logic [1:0] MODE_START     = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  entry_id;
		logic [15:0] start_tick;
		logic [15:0] total_cycles;
		logic [15:0] executed_cycles;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_id;
		logic [15:0] out_key;
		logic [4:0]  occupancy;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] key;
	} entry_t;

	typedef struct packed {
		logic   do_ins;
		logic   do_del;
		logic   is_pop;
		logic   sorted;
		entry_t fresh;
	} cell_ctl_t;

	typedef struct packed {
		logic   ins_p;
		logic   del_p;
		entry_t hit;
	} link_t;

endpackage

// ----- rtl/fosq_cell.sv -----
// One slot of the queue chain: holds an entry and shifts with its neighbors.
// Depends on fosq_pkg.
module fosq_cell import fosq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  link_t     link_in,
	output link_t     link_out,
	input  logic      left_valid,
	input  entry_t    left_ent,
	input  logic      right_valid,
	input  entry_t    right_ent,
	output logic      valid,
	output entry_t    ent
);

	logic   valid_q;
	entry_t ent_q;
	logic   place;
	logic   match;

	assign place = !valid_q || (ctl.sorted && (ctl.fresh.key < ent_q.key));
	assign match = valid_q && (ctl.is_pop || (ent_q.id == ctl.fresh.id));

	assign link_out.ins_p = link_in.ins_p | place;
	assign link_out.del_p = link_in.del_p | match;
	assign link_out.hit   = (match && !link_in.del_p) ? ent_q : link_in.hit;

	assign valid = valid_q;
	assign ent   = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.do_ins) begin
			if (link_in.ins_p) begin
				valid_q <= left_valid;
			end else if (place) begin
				valid_q <= 1'b1;
			end
		end else if (ctl.do_del && link_out.del_p) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.do_ins) begin
			if (link_in.ins_p) begin
				ent_q <= left_ent;
			end else if (place) begin
				ent_q <= ctl.fresh;
			end
		end else if (ctl.do_del && link_out.del_p) begin
			ent_q <= right_ent;
		end
	end

endmodule

// ----- rtl/fosq_obuf.sv -----
// Two-word output buffer: result register plus skid stage.
// Depends on fosq_pkg.
module fosq_obuf import fosq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_word_t push_word,
	output logic      space,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	logic      head_valid_q;
	out_word_t head_q;
	logic      skid_valid_q;
	out_word_t skid_q;
	logic      head_free;

	assign space     = !skid_valid_q;
	assign out_valid = head_valid_q;
	assign out_word  = head_q;
	assign head_free = !head_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (head_free) begin
			head_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_free) begin
			head_q <= skid_valid_q ? skid_q : push_word;
		end else if (push) begin
			skid_q <= push_word;
		end
	end

endmodule

// ----- rtl/fifo_or_sorted_process_queue_top.sv -----
// Process queue top level: a chain of DEPTH slot cells plus output buffer.
// Depends on fosq_pkg, fosq_cell and fosq_obuf.
//
// Takes one command word per cycle (insert, pop head, remove by id) and returns one result
// word per command through a two-word output buffer; the input stalls only while both
// buffer words wait on out_ready. Every cell compares its entry with the command in parallel
// and shifts left or right in the same cycle, so the cycle time is set by the insert-position
// and match carries rippling through all DEPTH cells. The queue mode is written on mode_we; the
// user must write it only while no command is in flight; the block does not enforce it. In
// sorted modes an insert goes just before the first stored entry with a larger key; stored keys
// are kept as they are across mode changes. The queue is empty after reset, with no clearing pass.
module fifo_or_sorted_process_queue_top import fosq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      mode_we,
	input  logic [1:0] mode_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [1:0]   mode_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic [CW+4:0] occ_ext;
	logic         accept;
	logic         full;
	logic         found;
	logic         sorted;
	logic [15:0]  new_key;
	cell_ctl_t    ctl;
	out_word_t    res;
	link_t        links [DEPTH+1];
	logic         cvalid [DEPTH];
	entry_t       cent [DEPTH];

	assign accept = in_valid && in_ready;
	assign full   = (count_q == CW'(DEPTH));
	assign sorted = (mode_q == MODE_REMAINING) || (mode_q == MODE_START);

	always_comb begin
		if (mode_q == MODE_REMAINING) begin
			new_key = (in_word.total_cycles > in_word.executed_cycles) ?
				(in_word.total_cycles - in_word.executed_cycles) : 16'd0;
		end else begin
			new_key = in_word.start_tick;
		end
	end

	always_comb begin
		ctl.do_ins    = accept && (in_word.cmd == CMD_INSERT) && !full;
		ctl.do_del    = accept && ((in_word.cmd == CMD_POP) || (in_word.cmd == CMD_REMOVE));
		ctl.is_pop    = (in_word.cmd == CMD_POP);
		ctl.sorted    = sorted;
		ctl.fresh.id  = in_word.entry_id;
		ctl.fresh.key = new_key;
	end

	assign links[0] = '0;
	assign found    = links[DEPTH].del_p;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   lv;
		entry_t le;
		logic   rv;
		entry_t re;
		if (i == 0) begin : g_first
			assign lv = 1'b0;
			assign le = '0;
		end else begin : g_mid
			assign lv = cvalid[i-1];
			assign le = cent[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign rv = 1'b0;
			assign re = '0;
		end else begin : g_inner
			assign rv = cvalid[i+1];
			assign re = cent[i+1];
		end
		fosq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.link_in     (links[i]),
			.link_out    (links[i+1]),
			.left_valid  (lv),
			.left_ent    (le),
			.right_valid (rv),
			.right_ent   (re),
			.valid       (cvalid[i]),
			.ent         (cent[i])
		);
	end

	always_comb begin
		count_next = count_q;
		if (ctl.do_ins) begin
			count_next = count_q + CW'(1);
		end else if (ctl.do_del && found) begin
			count_next = count_q - CW'(1);
		end
	end

	assign occ_ext = {5'd0, count_next};

	always_comb begin
		res.status    = ST_OK;
		res.out_id    = 8'd0;
		res.out_key   = 16'd0;
		res.occupancy = occ_ext[4:0];
		case (in_word.cmd)
			CMD_INSERT: begin
				if (full) begin
					res.status = ST_FULL;
				end
			end
			CMD_POP, CMD_REMOVE: begin
				if (found) begin
					res.out_id  = links[DEPTH].hit.id;
					res.out_key = links[DEPTH].hit.key;
				end else if (in_word.cmd == CMD_POP) begin
					res.status = ST_EMPTY;
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FIFO;
			count_q <= '0;
		end else begin
			if (mode_we) begin
				mode_q <= mode_wdata;
			end
			count_q <= count_next;
		end
	end

	fosq_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_word (res),
		.space     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule
